// ===== sv/fcsg_pkg.sv =====
// Package for the four-channel sound generator: field widths, codes,
// register offsets and the duty and output scaling tables.
// No dependencies.
`default_nettype none

package fcsg_pkg;

    // Item codes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_TRIGGER = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SAMPLE_PERIOD = 1'b0;
    localparam logic CFG_FRAME_PERIOD  = 1'b1;

    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd95;
    localparam logic [15:0] FRAME_PERIOD_RST  = 16'd8192;

    localparam int CHUNK_SAMPLES_DEF = 1024;

    // Sound register offsets from the base of the register block
    localparam int CTRL_REGS = 32;
    localparam int WAVE_BYTES = 16;
    localparam logic [5:0] WAVE_BASE = 6'd32;
    localparam logic [5:0] REG_END   = 6'd48;

    localparam logic [2:0] CH_SQ1   = 3'd1;
    localparam logic [2:0] CH_SQ2   = 3'd2;
    localparam logic [2:0] CH_WAVE  = 3'd3;
    localparam logic [2:0] CH_NOISE = 3'd4;

    // Waveform for each duty setting
    function automatic logic [7:0] duty_mask(input logic [1:0] sel);
        logic [7:0] m;
        case (sel)
            2'd0:    m = 8'h02;
            2'd1:    m = 8'h03;
            2'd2:    m = 8'h0F;
            default: m = 8'hFC;
        endcase
        return m;
    endfunction

    // floor(10000 * level / 15)
    function automatic logic [13:0] scale_level(input logic [3:0] lvl);
        logic [13:0] s;
        case (lvl)
            4'd0:    s = 14'd0;
            4'd1:    s = 14'd666;
            4'd2:    s = 14'd1333;
            4'd3:    s = 14'd2000;
            4'd4:    s = 14'd2666;
            4'd5:    s = 14'd3333;
            4'd6:    s = 14'd4000;
            4'd7:    s = 14'd4666;
            4'd8:    s = 14'd5333;
            4'd9:    s = 14'd6000;
            4'd10:   s = 14'd6666;
            4'd11:   s = 14'd7333;
            4'd12:   s = 14'd8000;
            4'd13:   s = 14'd8666;
            4'd14:   s = 14'd9333;
            default: s = 14'd10000;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fcsg_ifs.sv =====
// Channel interfaces of the four-channel sound generator: command items in,
// sample items out. Valid/ready handshake; no dependencies.
`default_nettype none

interface fcsg_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [5:0] reg_offset;
    logic [7:0] write_data;
    logic [2:0] channel;

    modport source (output valid, mode, reg_offset, write_data, channel, input ready);
    modport sink   (input valid, mode, reg_offset, write_data, channel, output ready);
endinterface

interface fcsg_smp_if;
    logic        valid;
    logic        ready;
    logic [15:0] mixed_sample;
    logic [3:0]  square1_level;
    logic [3:0]  square2_level;
    logic [3:0]  wave_level;
    logic [3:0]  noise_level;
    logic [3:0]  active_mask;
    logic [9:0]  sample_slot;

    modport source (output valid, mixed_sample, square1_level, square2_level, wave_level,
                    noise_level, active_mask, sample_slot, input ready);
    modport sink   (input valid, mixed_sample, square1_level, square2_level, wave_level,
                    noise_level, active_mask, sample_slot, output ready);
endinterface

`default_nettype wire

// ===== sv/four_channel_sound_generator.sv =====
// Four-channel sound generator top level: square, wave and noise channels,
// frame sequencer and sample mixer. Uses fcsg_pkg and fcsg_ifs.
//
//   port     | dir | carries
//   cmd      | in  | tick / register write / trigger items
//   sample   | out | mixed sample, four levels, active bits, chunk slot
//   cfg_*    | in  | sample_period (index 0), frame_period (index 1)
//
// One item per clock while cmd.ready is high. Channel state updates in the
// cycle an item transfers; the wave RAM read issued by that tick returns in the
// next cycle and the sample is mixed then from the mix stage registers; the
// mixed sample then loads the output register. Reset clears the channel
// state; wave RAM bytes read as zero until written, so no clearing pass is
// needed. A stalled sample output holds the mix stage and deasserts cmd.ready.
`default_nettype none

module four_channel_sound_generator #(
    parameter int CHUNK_SAMPLES = fcsg_pkg::CHUNK_SAMPLES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    fcsg_cmd_if.sink    cmd,
    fcsg_smp_if.source  sample,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire [15:0]  cfg_data
);

    localparam int SLOT_W = (CHUNK_SAMPLES > 1) ? $clog2(CHUNK_SAMPLES) : 1;

    // Configuration
    logic [15:0] sample_period_reg;
    logic [15:0] frame_period_reg;

    // Channel state
    logic [7:0]  regs_reg [fcsg_pkg::CTRL_REGS];
    logic [7:0]  regs_next [fcsg_pkg::CTRL_REGS];
    logic [2:0]  duty_pos_reg [2];
    logic [2:0]  duty_pos_next [2];
    logic [11:0] pc_reg [3];
    logic [11:0] pc_next [3];
    logic [4:0]  wave_pos_reg, wave_pos_next;
    logic [3:0]  wave_nib_reg;
    logic [14:0] noise_shift_reg, noise_shift_next;
    logic [21:0] noise_cnt_reg, noise_cnt_next;
    logic        noise_bit_reg, noise_bit_next;
    logic [15:0] dot_reg, dot_next;
    logic [2:0]  frame_step_reg, frame_step_next;
    logic [8:0]  len_reg [4];
    logic [8:0]  len_next [4];
    logic [3:0]  vol_reg [3];
    logic [3:0]  vol_next [3];
    logic [2:0]  env_cnt_reg [3];
    logic [2:0]  env_cnt_next [3];
    logic [1:0]  env_dir_reg, env_dir_next;
    logic [2:0]  env_pace_reg [2];
    logic [2:0]  env_pace_next [2];
    logic [2:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [3:0]  active_reg, active_next;
    logic [15:0] timer_reg, timer_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // Wave RAM
    logic [7:0]  wave_mem [fcsg_pkg::WAVE_BYTES];
    logic [7:0]  wave_rd_reg;
    logic        wave_rd_en;
    logic [3:0]  wave_rd_addr;
    logic        wave_we;
    logic [15:0] wave_ok_reg;
    logic        wave_rd_ok_reg;
    logic [7:0]  wave_byte;
    logic        pend_reg;
    logic        pend_par_reg;
    logic [3:0]  wave_cur;

    // Mix stage and output register
    logic        s1_valid_reg;
    logic [3:0]  s1_l1_reg, s1_l2_reg, s1_l4_reg, s1_act_reg;
    logic [9:0]  s1_slot_reg;
    logic        emit;
    logic [3:0]  l1, l2, l4;
    logic        out_valid_reg;
    logic        out_load;
    logic        accept;
    logic [15:0] mix;
    logic [16:0] slot_ext;

    assign out_load  = s1_valid_reg && (!out_valid_reg || sample.ready);
    assign cmd.ready = !s1_valid_reg || out_load;
    assign accept    = cmd.valid && cmd.ready;
    assign slot_ext  = 17'(slot_reg);
    assign wave_we   = accept && cmd.mode == fcsg_pkg::MODE_WRITE
                       && cmd.reg_offset >= fcsg_pkg::WAVE_BASE
                       && cmd.reg_offset < fcsg_pkg::REG_END;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= fcsg_pkg::SAMPLE_PERIOD_RST;
            frame_period_reg  <= fcsg_pkg::FRAME_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fcsg_pkg::CFG_SAMPLE_PERIOD)
                sample_period_reg <= cfg_data;
            else
                frame_period_reg <= cfg_data;
        end
    end

    // Per-item state update
    always_comb
    begin
        logic [10:0] reload;
        logic [6:0]  nbase;
        logic [22:0] nlimit;
        logic [22:0] ncnt;
        logic        nb;
        logic [3:0]  step;
        logic [2:0]  pace;
        logic [2:0]  slope;
        logic [10:0] old_p;
        logic [10:0] delta;
        logic [11:0] nw;
        logic [3:0]  ecnt;
        logic [16:0] tinc;
        logic [16:0] sinc;
        logic [8:0]  limit;
        logic [7:0]  ctrl;
        logic [7:0]  dm1;
        logic [7:0]  dm2;

        regs_next        = regs_reg;
        duty_pos_next    = duty_pos_reg;
        pc_next          = pc_reg;
        wave_pos_next    = wave_pos_reg;
        noise_shift_next = noise_shift_reg;
        noise_cnt_next   = noise_cnt_reg;
        noise_bit_next   = noise_bit_reg;
        dot_next         = dot_reg;
        frame_step_next  = frame_step_reg;
        len_next         = len_reg;
        vol_next         = vol_reg;
        env_cnt_next     = env_cnt_reg;
        env_dir_next     = env_dir_reg;
        env_pace_next    = env_pace_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        active_next      = active_reg;
        timer_next       = timer_reg;
        slot_next        = slot_reg;
        wave_rd_en       = 1'b0;
        wave_rd_addr     = wave_pos_reg[4:1];
        emit             = 1'b0;
        l1 = '0;
        l2 = '0;
        l4 = '0;
        reload = '0; nbase = '0; nlimit = '0; ncnt = '0; nb = 1'b0; step = '0;
        pace = '0; slope = '0; old_p = '0; delta = '0; nw = '0; ecnt = '0;
        tinc = '0; sinc = '0; limit = '0; ctrl = '0; dm1 = '0; dm2 = '0;

        if (accept)
        begin
            case (cmd.mode)
                fcsg_pkg::MODE_WRITE:
                begin
                    if (cmd.reg_offset < fcsg_pkg::WAVE_BASE)
                        regs_next[cmd.reg_offset[4:0]] = cmd.write_data;
                end
                fcsg_pkg::MODE_TRIGGER:
                begin
                    case (cmd.channel)
                        fcsg_pkg::CH_SQ1:
                        begin
                            len_next[0]      = {3'd0, regs_reg[1][5:0]};
                            vol_next[0]      = regs_reg[2][7:4];
                            env_dir_next[0]  = regs_reg[2][3];
                            env_pace_next[0] = regs_reg[2][2:0];
                            sweep_cnt_next   = regs_reg[0][6:4];
                            active_next[0]   = 1'b1;
                        end
                        fcsg_pkg::CH_SQ2:
                        begin
                            len_next[1]      = {3'd0, regs_reg[6][5:0]};
                            vol_next[1]      = regs_reg[7][7:4];
                            env_dir_next[1]  = regs_reg[7][3];
                            env_pace_next[1] = regs_reg[7][2:0];
                            active_next[1]   = 1'b1;
                        end
                        fcsg_pkg::CH_WAVE:
                        begin
                            len_next[2]    = {1'b0, regs_reg[11]};
                            active_next[2] = 1'b1;
                        end
                        fcsg_pkg::CH_NOISE:
                        begin
                            len_next[3]      = {3'd0, regs_reg[16][5:0]};
                            vol_next[2]      = regs_reg[17][7:4];
                            noise_shift_next = '0;
                            active_next[3]   = 1'b1;
                        end
                        default: ;
                    endcase
                end
                fcsg_pkg::MODE_TICK:
                begin
                    // Square period timers, every fourth dot
                    if (dot_reg[1:0] == 2'd0)
                    begin
                        for (int i = 0; i < 2; i++)
                        begin
                            if (pc_reg[i][11])
                            begin
                                duty_pos_next[i] = duty_pos_reg[i] + 3'd1;
                                reload = (i == 0) ? {regs_reg[4][2:0], regs_reg[3]}
                                                  : {regs_reg[9][2:0], regs_reg[8]};
                                pc_next[i] = {1'b0, reload} + 12'd1;
                            end
                            else
                                pc_next[i] = pc_reg[i] + 12'd1;
                        end
                    end

                    // Wave timer, every second dot; fetch the next sample byte
                    if (!dot_reg[0])
                    begin
                        if (pc_reg[2][11])
                        begin
                            wave_pos_next = wave_pos_reg + 5'd1;
                            wave_rd_en    = 1'b1;
                            wave_rd_addr  = wave_pos_next[4:1];
                            pc_next[2] = {1'b0, regs_reg[14][2:0], regs_reg[13]} + 12'd1;
                        end
                        else
                            pc_next[2] = pc_reg[2] + 12'd1;
                    end

                    // Noise divider and LFSR
                    nbase  = (regs_reg[18][2:0] == 3'd0) ? 7'd8 : {regs_reg[18][2:0], 4'd0};
                    nlimit = 23'(nbase) << regs_reg[18][7:4];
                    ncnt   = 23'(noise_cnt_reg) + 23'd1;
                    if (ncnt >= nlimit)
                    begin
                        noise_bit_next   = noise_shift_reg[0];
                        nb               = ~(noise_shift_reg[0] ^ noise_shift_reg[1]);
                        noise_shift_next = {nb, noise_shift_reg[14:1]};
                        if (regs_reg[18][3])
                            noise_shift_next[6] = nb;
                        noise_cnt_next = '0;
                    end
                    else
                        noise_cnt_next = ncnt[21:0];

                    // Frame sequencer
                    if (dot_reg >= frame_period_reg)
                    begin
                        step = {1'b0, frame_step_reg} + 4'd1;
                        if (!step[0])
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                limit = (i == 2) ? 9'd256 : 9'd64;
                                ctrl  = regs_reg[5'(4 + 5 * i)];
                                if (ctrl[6] && (len_reg[i] < limit))
                                begin
                                    len_next[i] = len_reg[i] + 9'd1;
                                    if (len_next[i] == limit)
                                        active_next[i] = 1'b0;
                                end
                            end
                        end
                        if (step == 4'd7)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pace = (i == 2) ? regs_reg[17][2:0] : env_pace_reg[i];
                                nb   = (i == 2) ? regs_reg[17][3] : env_dir_reg[i];
                                if (pace != 3'd0)
                                begin
                                    ecnt = {1'b0, env_cnt_reg[i]} + 4'd1;
                                    if (ecnt >= {1'b0, pace})
                                    begin
                                        if (nb && vol_reg[i] != 4'd15)
                                            vol_next[i] = vol_reg[i] + 4'd1;
                                        else if (!nb && vol_reg[i] != 4'd0)
                                            vol_next[i] = vol_reg[i] - 4'd1;
                                        env_cnt_next[i] = '0;
                                    end
                                    else
                                        env_cnt_next[i] = ecnt[2:0];
                                end
                            end
                        end
                        // Channel 1 sweep
                        pace  = regs_reg[0][6:4];
                        slope = regs_reg[0][2:0];
                        if ((step == 4'd2 || step == 4'd6) && pace != 3'd0)
                        begin
                            if (sweep_cnt_reg > 3'd1)
                                sweep_cnt_next = sweep_cnt_reg - 3'd1;
                            else
                            begin
                                old_p = {regs_reg[4][2:0], regs_reg[3]};
                                delta = old_p >> slope;
                                nw = regs_reg[0][3] ? ({1'b0, old_p} - {1'b0, delta})
                                                    : ({1'b0, old_p} + {1'b0, delta});
                                if (nw[11])
                                    active_next[0] = 1'b0;
                                else if (slope != 3'd0)
                                begin
                                    regs_next[4] = {regs_reg[4][7:3], nw[10:8]};
                                    regs_next[3] = nw[7:0];
                                end
                                sweep_cnt_next = pace;
                            end
                        end
                        frame_step_next = step[2:0];
                        dot_next = 16'd1;
                    end
                    else
                        dot_next = dot_reg + 16'd1;

                    // Sample timer
                    tinc = 17'(timer_reg) + 17'd1;
                    if (tinc >= 17'(sample_period_reg))
                    begin
                        timer_next = '0;
                        emit = 1'b1;
                        dm1 = fcsg_pkg::duty_mask(regs_reg[1][7:6]);
                        dm2 = fcsg_pkg::duty_mask(regs_reg[6][7:6]);
                        l1 = dm1[duty_pos_next[0]] ? vol_next[0] : 4'd0;
                        l2 = dm2[duty_pos_next[1]] ? vol_next[1] : 4'd0;
                        l4 = noise_bit_next ? vol_next[2] : 4'd0;
                        sinc = slot_ext + 17'd1;
                        slot_next = (sinc >= 17'(CHUNK_SAMPLES)) ? '0 : sinc[SLOT_W-1:0];
                    end
                    else
                        timer_next = tinc[15:0];
                end
                default: ;
            endcase
        end
    end

    // Hold channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fcsg_pkg::CTRL_REGS; i++)
                regs_reg[i] <= '0;
            for (int i = 0; i < 2; i++)
            begin
                duty_pos_reg[i] <= '0;
                env_pace_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                pc_reg[i]      <= '0;
                vol_reg[i]     <= '0;
                env_cnt_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
                len_reg[i] <= '0;
            wave_pos_reg    <= '0;
            noise_shift_reg <= '0;
            noise_cnt_reg   <= '0;
            noise_bit_reg   <= 1'b0;
            dot_reg         <= '0;
            frame_step_reg  <= '0;
            env_dir_reg     <= '0;
            sweep_cnt_reg   <= '0;
            active_reg      <= '0;
            timer_reg       <= '0;
            slot_reg        <= '0;
        end
        else
        begin
            regs_reg        <= regs_next;
            duty_pos_reg    <= duty_pos_next;
            pc_reg          <= pc_next;
            wave_pos_reg    <= wave_pos_next;
            noise_shift_reg <= noise_shift_next;
            noise_cnt_reg   <= noise_cnt_next;
            noise_bit_reg   <= noise_bit_next;
            dot_reg         <= dot_next;
            frame_step_reg  <= frame_step_next;
            len_reg         <= len_next;
            vol_reg         <= vol_next;
            env_cnt_reg     <= env_cnt_next;
            env_dir_reg     <= env_dir_next;
            env_pace_reg    <= env_pace_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            active_reg      <= active_next;
            timer_reg       <= timer_next;
            slot_reg        <= slot_next;
        end
    end

    // Wave RAM: write on register transfers, read on position advance
    always_ff @(posedge clk)
    begin
        if (wave_we)
            wave_mem[cmd.reg_offset[3:0]] <= cmd.write_data;
        if (wave_rd_en)
            wave_rd_reg <= wave_mem[wave_rd_addr];
    end

    // Track written wave bytes; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_ok_reg    <= '0;
            wave_rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wave_we)
                wave_ok_reg[cmd.reg_offset[3:0]] <= 1'b1;
            if (wave_rd_en)
                wave_rd_ok_reg <= wave_ok_reg[wave_rd_addr];
        end
    end

    // Select the nibble once the read data returns
    assign wave_byte = wave_rd_ok_reg ? wave_rd_reg : 8'd0;
    assign wave_cur = !pend_reg ? wave_nib_reg
                    : (pend_par_reg ? wave_byte[3:0] : wave_byte[7:4]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            pend_par_reg <= 1'b0;
            wave_nib_reg <= '0;
        end
        else
        begin
            pend_reg     <= wave_rd_en;
            pend_par_reg <= wave_pos_next[0];
            wave_nib_reg <= wave_cur;
        end
    end

    // Mix stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cmd.ready)
            s1_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && emit)
        begin
            s1_l1_reg   <= l1;
            s1_l2_reg   <= l2;
            s1_l4_reg   <= l4;
            s1_act_reg  <= active_next;
            s1_slot_reg <= slot_ext[9:0];
        end
    end

    assign mix = 16'((s1_act_reg[0] ? fcsg_pkg::scale_level(s1_l1_reg) : 14'd0))
               + 16'((s1_act_reg[1] ? fcsg_pkg::scale_level(s1_l2_reg) : 14'd0))
               + 16'((s1_act_reg[2] ? fcsg_pkg::scale_level(wave_cur)  : 14'd0))
               + 16'((s1_act_reg[3] ? fcsg_pkg::scale_level(s1_l4_reg) : 14'd0));

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (sample.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample.mixed_sample  <= mix;
            sample.square1_level <= s1_l1_reg;
            sample.square2_level <= s1_l2_reg;
            sample.wave_level    <= wave_cur;
            sample.noise_level   <= s1_l4_reg;
            sample.active_mask   <= s1_act_reg;
            sample.sample_slot   <= s1_slot_reg;
        end
    end

    assign sample.valid = out_valid_reg;

endmodule

`default_nettype wire
